[rtl/grm_pkg.sv]
package grm_pkg;

    localparam int COORD_W         = 3;
    localparam int CELL_W          = 2 * COORD_W;
    localparam int CELLS           = 1 << CELL_W;
    localparam int DEF_GRID_SIDE   = 8;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int STEP_W          = 4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WAIT,
        OP_PUSH,
        OP_POP,
        OP_MATCH,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        DIR_SELF,
        DIR_DOWN,
        DIR_UP,
        DIR_RIGHT,
        DIR_LEFT
    } dir_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ACCEPT,
        COND_END_WALL,
        COND_EMPTY,
        COND_HIT,
        COND_ALWAYS,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t               op;
        dir_t              dir;
        cond_t             cond;
        logic              hold;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic load;
        op_t  op;
        dir_t dir;
    } dp_ctl_t;

    typedef struct packed {
        logic stack_empty;
        logic end_open;
        logic hit;
        logic found;
    } dp_status_t;

    localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_ENDCHK = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SEED   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_POP    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_MATCH  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DOWN   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_UP     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_RIGHT  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_LEFT   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_DONE   = 4'd9;

endpackage

[rtl/grm_ucode_rom.sv]
module grm_ucode_rom (
    input  logic [grm_pkg::STEP_W-1:0] step,
    output grm_pkg::ucode_t            word
);
    import grm_pkg::*;

    always_comb
    begin
        case (step)
            STEP_WAIT:   word = '{OP_WAIT,  DIR_SELF,  COND_ACCEPT,   1'b1, STEP_ENDCHK};
            STEP_ENDCHK: word = '{OP_NOP,   DIR_SELF,  COND_END_WALL, 1'b0, STEP_DONE};
            STEP_SEED:   word = '{OP_PUSH,  DIR_SELF,  COND_NONE,     1'b0, STEP_WAIT};
            STEP_POP:    word = '{OP_POP,   DIR_SELF,  COND_EMPTY,    1'b0, STEP_DONE};
            STEP_MATCH:  word = '{OP_MATCH, DIR_SELF,  COND_HIT,      1'b0, STEP_DONE};
            STEP_DOWN:   word = '{OP_PUSH,  DIR_DOWN,  COND_NONE,     1'b0, STEP_WAIT};
            STEP_UP:     word = '{OP_PUSH,  DIR_UP,    COND_NONE,     1'b0, STEP_WAIT};
            STEP_RIGHT:  word = '{OP_PUSH,  DIR_RIGHT, COND_NONE,     1'b0, STEP_WAIT};
            STEP_LEFT:   word = '{OP_PUSH,  DIR_LEFT,  COND_ALWAYS,   1'b0, STEP_POP};
            STEP_DONE:   word = '{OP_DONE,  DIR_SELF,  COND_OUT_FREE, 1'b1, STEP_WAIT};
            default:     word = '{OP_NOP,   DIR_SELF,  COND_ALWAYS,   1'b0, STEP_WAIT};
        endcase
    end

endmodule

[rtl/grm_datapath.sv]
module grm_datapath #(
    parameter int GRID_SIDE   = grm_pkg::DEF_GRID_SIDE,
    parameter int STACK_DEPTH = grm_pkg::DEF_STACK_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  grm_pkg::dp_ctl_t             ctl,
    input  logic                         cfg_we,
    input  logic [grm_pkg::CELLS-1:0]    cfg_wdata,
    input  logic [grm_pkg::COORD_W-1:0]  start_row,
    input  logic [grm_pkg::COORD_W-1:0]  start_col,
    input  logic [grm_pkg::COORD_W-1:0]  end_row,
    input  logic [grm_pkg::COORD_W-1:0]  end_col,
    output grm_pkg::dp_status_t          status
);
    import grm_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [COORD_W:0] SIDE  = (COORD_W + 1)'(GRID_SIDE);
    localparam logic [COORD_W:0] NB_ONE = (COORD_W + 1)'(1);
    localparam logic [CW-1:0]    DEPTH = CW'(STACK_DEPTH);

    logic [CELLS-1:0]   wall_map_reg;
    logic [CELLS-1:0]   visited_reg;
    logic [COORD_W-1:0] cur_row_reg;
    logic [COORD_W-1:0] cur_col_reg;
    logic [COORD_W-1:0] end_row_reg;
    logic [COORD_W-1:0] end_col_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CELL_W-1:0]  rdata_reg;
    logic               found_reg;
    logic [CELL_W-1:0]  stack_mem [STACK_DEPTH];

    logic [COORD_W:0]   nb_row;
    logic [COORD_W:0]   nb_col;
    logic [CELL_W-1:0]  nb_cell;
    logic [CELL_W-1:0]  end_cell;
    logic               nb_open;
    logic               end_open;
    logic               push_en;
    logic               pop_en;
    logic               stack_empty;
    logic [CW-1:0]      cnt_dec;
    logic [AW-1:0]      push_addr;
    logic [AW-1:0]      pop_addr;

    always_comb
    begin
        case (ctl.dir)
            DIR_DOWN:
            begin
                nb_row = {1'b0, cur_row_reg} + NB_ONE;
                nb_col = {1'b0, cur_col_reg};
            end
            DIR_UP:
            begin
                nb_row = {1'b0, cur_row_reg} - NB_ONE;
                nb_col = {1'b0, cur_col_reg};
            end
            DIR_RIGHT:
            begin
                nb_row = {1'b0, cur_row_reg};
                nb_col = {1'b0, cur_col_reg} + NB_ONE;
            end
            DIR_LEFT:
            begin
                nb_row = {1'b0, cur_row_reg};
                nb_col = {1'b0, cur_col_reg} - NB_ONE;
            end
            default:
            begin
                nb_row = {1'b0, cur_row_reg};
                nb_col = {1'b0, cur_col_reg};
            end
        endcase
    end

    // off-grid neighbors wrap above the side and count as walls
    assign nb_cell     = {nb_row[COORD_W-1:0], nb_col[COORD_W-1:0]};
    assign nb_open     = (nb_row < SIDE) && (nb_col < SIDE) && !wall_map_reg[nb_cell];
    assign end_cell    = {end_row_reg, end_col_reg};
    assign end_open    = ({1'b0, end_row_reg} < SIDE) && ({1'b0, end_col_reg} < SIDE)
                         && !wall_map_reg[end_cell];
    assign stack_empty = (cnt_reg == '0);
    assign push_en     = (ctl.op == OP_PUSH) && nb_open && !visited_reg[nb_cell]
                         && (cnt_reg < DEPTH);
    assign pop_en      = (ctl.op == OP_POP) && !stack_empty;
    assign cnt_dec     = cnt_reg - CW'(1);
    assign push_addr   = cnt_reg[AW-1:0];
    assign pop_addr    = cnt_dec[AW-1:0];

    assign status.stack_empty = stack_empty;
    assign status.end_open    = end_open;
    assign status.hit         = (rdata_reg == end_cell);
    assign status.found       = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_map_reg <= '0;
            visited_reg  <= '0;
            cnt_reg      <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wall_map_reg <= cfg_wdata;
            end
            if (ctl.load)
            begin
                visited_reg <= '0;
                cnt_reg     <= '0;
                found_reg   <= 1'b0;
            end
            else if (push_en)
            begin
                visited_reg[nb_cell] <= 1'b1;
                cnt_reg              <= cnt_reg + CW'(1);
            end
            else if (pop_en)
            begin
                cnt_reg <= cnt_dec;
            end
            if ((ctl.op == OP_MATCH) && status.hit)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cur_row_reg <= start_row;
            cur_col_reg <= start_col;
            end_row_reg <= end_row;
            end_col_reg <= end_col;
        end
        else if (ctl.op == OP_MATCH)
        begin
            cur_row_reg <= rdata_reg[CELL_W-1:COORD_W];
            cur_col_reg <= rdata_reg[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[push_addr] <= nb_cell;
        end
        if (pop_en)
        begin
            rdata_reg <= stack_mem[pop_addr];
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH)
        else $error("stack count above depth");

    a_push_marks: assert property (@(posedge clk) disable iff (!rst_n)
        push_en && !ctl.load |=> visited_reg[$past(nb_cell)] && (cnt_reg != '0))
        else $error("pushed cell not marked visited");

endmodule

[rtl/grid_maze_reachability_unit.sv]
// channel   signals                                      dir   meaning
// request   in_valid in_stall start_row/col end_row/col  in    one query
// result    out_valid out_stall reachable                out   one answer per query
// config    cfg_we cfg_wdata                             in    64-bit wall map
//
// a query pops each open cell at most once, so at most 64 cells, and runs
// a microcode loop of one pop, one compare and four neighbor pushes per cell
// in_stall is high from acceptance until the answer is loaded into the output register
// the answer waits in the output register while out_stall is high
// reset clears the wall map, the visited map, the stack count and the sequencer
module grid_maze_reachability_unit #(
    parameter int GRID_SIDE   = grm_pkg::DEF_GRID_SIDE,
    parameter int STACK_DEPTH = grm_pkg::DEF_STACK_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [grm_pkg::COORD_W-1:0]  start_row,
    input  logic [grm_pkg::COORD_W-1:0]  start_col,
    input  logic [grm_pkg::COORD_W-1:0]  end_row,
    input  logic [grm_pkg::COORD_W-1:0]  end_col,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         reachable,
    input  logic                         cfg_we,
    input  logic [grm_pkg::CELLS-1:0]    cfg_wdata
);
    import grm_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              reachable_reg;
    logic              reachable_next;
    ucode_t            word;
    dp_ctl_t           ctl;
    dp_status_t        status;
    logic              in_accept;
    logic              out_free;
    logic              cond_true;

    grm_ucode_rom u_rom (
        .step (step_reg),
        .word (word)
    );

    grm_datapath #(
        .GRID_SIDE   (GRID_SIDE),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start_row (start_row),
        .start_col (start_col),
        .end_row   (end_row),
        .end_col   (end_col),
        .status    (status)
    );

    assign in_stall  = (word.op != OP_WAIT);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign ctl.load = in_accept;
    assign ctl.op   = word.op;
    assign ctl.dir  = word.dir;

    always_comb
    begin
        case (word.cond)
            COND_ACCEPT:   cond_true = in_accept;
            COND_END_WALL: cond_true = !status.end_open;
            COND_EMPTY:    cond_true = status.stack_empty;
            COND_HIT:      cond_true = status.hit;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_OUT_FREE: cond_true = out_free;
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_true)
        begin
            step_next = word.target;
        end
        else if (word.hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_reg + STEP_W'(1);
        end

        out_valid_next = out_valid_reg && out_stall;
        reachable_next = reachable_reg;
        if ((word.op == OP_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
            reachable_next = status.found;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_WAIT;
            out_valid_reg <= 1'b0;
            reachable_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            reachable_reg <= reachable_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign reachable = reachable_reg;

    a_accept_leaves_wait: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> step_reg == STEP_ENDCHK)
        else $error("request accepted but sequencer did not start");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_reg) == STEP_DONE)
        else $error("result raised outside the done step");

endmodule

[bench/grid_maze_reachability_unit_tb.sv]
module grid_maze_reachability_unit_tb;

    import grm_pkg::*;

    localparam int NPROBES     = 22;
    localparam int PHASES      = 17;
    localparam int PHASE_ITEMS = 100;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 1000;
    localparam int DRAIN       = 400;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CELLS-1:0]   walls_t;

    typedef struct packed {
        logic   load_map;
        walls_t walls;
        coord_t sr;
        coord_t sc;
        coord_t er;
        coord_t ec;
        logic   known;
        logic   answer;
    } probe_row_t;

    localparam walls_t OPEN   = '0;
    localparam walls_t SOLID  = '1;
    localparam walls_t COL3   = 64'h0808080808080808;
    localparam walls_t SNAKE  = 64'hFE007F00FE007F00;
    localparam walls_t CHECKS = 64'hAA55AA55AA55AA55;

    localparam probe_row_t PROBES [NPROBES] = '{
        // map after reset, all open
        '{1'b0, OPEN,  3'd0, 3'd0, 3'd7, 3'd7, 1'b1, 1'b1},
        '{1'b0, OPEN,  3'd7, 3'd7, 3'd0, 3'd0, 1'b1, 1'b1},
        '{1'b0, OPEN,  3'd3, 3'd4, 3'd3, 3'd4, 1'b1, 1'b1},
        '{1'b0, OPEN,  3'd7, 3'd0, 3'd0, 3'd7, 1'b1, 1'b1},
        // every cell a wall
        '{1'b1, SOLID, 3'd0, 3'd0, 3'd0, 3'd0, 1'b1, 1'b0},
        '{1'b0, OPEN,  3'd7, 3'd7, 3'd7, 3'd0, 1'b1, 1'b0},
        // wall at the corner endpoint
        '{1'b1, 64'h1, 3'd0, 3'd0, 3'd5, 3'd5, 1'b1, 1'b0},
        '{1'b0, OPEN,  3'd5, 3'd5, 3'd0, 3'd0, 1'b1, 1'b0},
        '{1'b0, OPEN,  3'd1, 3'd1, 3'd1, 3'd1, 1'b0, 1'b0},
        // wall column splits the grid
        '{1'b1, COL3,  3'd0, 3'd0, 3'd0, 3'd7, 1'b1, 1'b0},
        '{1'b0, OPEN,  3'd0, 3'd0, 3'd7, 3'd2, 1'b0, 1'b0},
        '{1'b0, OPEN,  3'd7, 3'd7, 3'd0, 3'd4, 1'b0, 1'b0},
        '{1'b0, OPEN,  3'd7, 3'd4, 3'd0, 3'd7, 1'b0, 1'b0},
        // long winding corridor
        '{1'b1, SNAKE, 3'd0, 3'd0, 3'd6, 3'd0, 1'b0, 1'b0},
        '{1'b0, OPEN,  3'd0, 3'd0, 3'd7, 3'd0, 1'b0, 1'b0},
        '{1'b0, OPEN,  3'd6, 3'd7, 3'd0, 3'd7, 1'b0, 1'b0},
        '{1'b0, OPEN,  3'd2, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0},
        // isolated open cells
        '{1'b1, CHECKS, 3'd0, 3'd1, 3'd0, 3'd1, 1'b0, 1'b0},
        '{1'b0, OPEN,  3'd0, 3'd1, 3'd1, 3'd0, 1'b0, 1'b0},
        '{1'b0, OPEN,  3'd7, 3'd6, 3'd7, 3'd6, 1'b0, 1'b0},
        // wall at the far corner only
        '{1'b1, 64'h8000000000000000, 3'd0, 3'd0, 3'd7, 3'd7, 1'b1, 1'b0},
        '{1'b0, OPEN,  3'd7, 3'd6, 3'd0, 3'd0, 1'b0, 1'b0}
    };

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    coord_t start_row;
    coord_t start_col;
    coord_t end_row;
    coord_t end_col;
    logic   out_valid;
    logic   out_stall;
    logic   reachable;
    logic   cfg_we;
    walls_t cfg_wdata;

    walls_t walls_now;
    logic   answer_q[$];
    int     mismatches;
    int     answers_seen;
    int     cycles;
    bit     steady;

    grid_maze_reachability_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_row (start_row),
        .start_col (start_col),
        .end_row   (end_row),
        .end_col   (end_col),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .reachable (reachable),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // depth-first flood from the start, neighbors marked when pushed
    function automatic logic reach_of(walls_t walls, coord_t sr, coord_t sc,
                                      coord_t er, coord_t ec);
        logic [CELLS-1:0]    seen;
        logic [CELL_W-1:0]   pend [CELLS];
        logic [CELL_W-1:0]   spot;
        logic [CELL_W-1:0]   nb;
        int                  depth;
        int                  r;
        int                  c;
        int                  nr;
        int                  nc;
        int                  dr [4];
        int                  dc [4];
        dr = '{1, -1, 0, 0};
        dc = '{0, 0, 1, -1};
        if (walls[{sr, sc}] || walls[{er, ec}])
            return 1'b0;
        seen = '0;
        seen[{sr, sc}] = 1'b1;
        pend[0] = {sr, sc};
        depth = 1;
        while (depth > 0)
        begin
            depth--;
            spot = pend[depth];
            if (spot == {er, ec})
                return 1'b1;
            r = int'(spot[CELL_W-1:COORD_W]);
            c = int'(spot[COORD_W-1:0]);
            for (int d = 0; d < 4; d++)
            begin
                nr = r + dr[d];
                nc = c + dc[d];
                if (nr >= 0 && nr < DEF_GRID_SIDE && nc >= 0 && nc < DEF_GRID_SIDE)
                begin
                    nb = CELL_W'(nr * DEF_GRID_SIDE + nc);
                    if (!walls[nb] && !seen[nb] && depth < DEF_STACK_DEPTH)
                    begin
                        seen[nb] = 1'b1;
                        pend[depth] = nb;
                        depth++;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    function automatic walls_t random_walls(int density);
        walls_t w;
        for (int b = 0; b < CELLS; b++)
            w[b] = ($urandom_range(0, 15) < density);
        return w;
    endfunction

    function automatic logic [CELL_W-1:0] pick_spot(walls_t walls, bit open_only);
        logic [CELL_W-1:0] spot;
        spot = CELL_W'($urandom_range(0, CELLS - 1));
        if (open_only && walls != SOLID)
            for (int k = 0; k < 400 && walls[spot]; k++)
                spot = CELL_W'($urandom_range(0, CELLS - 1));
        return spot;
    endfunction

    task automatic submit(input coord_t sr, input coord_t sc, input coord_t er,
                          input coord_t ec, input logic known, input logic answer);
        logic taken;
        start_row <= sr;
        start_col <= sc;
        end_row   <= er;
        end_col   <= ec;
        in_valid  <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            if (taken)
                answer_q.push_back(known ? answer : reach_of(walls_now, sr, sc, er, ec));
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic idle_sender();
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wall map changes only once every answer is back
    task automatic load_walls(input walls_t w);
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        walls_now = w;
    endtask

    initial
    begin
        int          stall_left;
        bit          held_off;
        logic        took;
        logic        want;
        out_stall = 1'b0;
        stall_left = 0;
        held_off = 1'b0;
        answers_seen = 0;
        mismatches = 0;
        forever
        begin
            @(negedge clk);
            took = rst_n && out_valid && !out_stall;
            if (took)
            begin
                answers_seen++;
                if (answer_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: answer %0b arrived with no request pending",
                             $time, reachable);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (reachable !== want)
                    begin
                        mismatches++;
                        $display("%0t: reachable expected %0b actual %0b",
                                 $time, want, reachable);
                    end
                end
            end
            @(posedge clk);
            if (!held_off && answers_seen == HOLD_AFTER)
            begin
                held_off = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (took)
                stall_left = steady ? 0 : pick_gap();
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int                density_tab [7];
        walls_t            map;
        logic [CELL_W-1:0] src;
        logic [CELL_W-1:0] dst;
        bit                well;
        density_tab = '{2, 4, 5, 6, 7, 8, 11};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        start_row = '0;
        start_col = '0;
        end_row   = '0;
        end_col   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        walls_now = '0;
        steady    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NPROBES; i++)
        begin
            if (PROBES[i].load_map)
                load_walls(PROBES[i].walls);
            submit(PROBES[i].sr, PROBES[i].sc, PROBES[i].er, PROBES[i].ec,
                   PROBES[i].known, PROBES[i].answer);
            idle_sender();
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                map = OPEN;
            else if (p == 1)
                map = SOLID;
            else
                map = random_walls(density_tab[p % 7]);
            load_walls(map);
            steady = (p % 5 == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // mostly open endpoints so the search goes deep
                well = ($urandom_range(0, 99) < 85);
                src = pick_spot(walls_now, well);
                dst = ($urandom_range(0, 19) == 0) ? src : pick_spot(walls_now, well);
                submit(src[CELL_W-1:COORD_W], src[COORD_W-1:0],
                       dst[CELL_W-1:COORD_W], dst[COORD_W-1:0], 1'b0, 1'b0);
                idle_sender();
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
